>>> hdl/mpe_pkg.sv
// shared types, constants and the microcode table of the midpoint ellipse rasterizer
`timescale 1ns / 1ps
`default_nettype none
package mpe_pkg;

  localparam int AXIS_BITS_DEF  = 10;
  localparam int COORD_BITS_DEF = 11;

  // each output coordinate is 13 bits, two's complement
  localparam int OUT_BITS   = 13;
  localparam int OUT_DATA_W = ((4 * OUT_BITS + 7) / 8) * 8;

  localparam int CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_X = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_Y = 2'd1;

  localparam int CENTER_X_RESET = 300;
  localparam int CENTER_Y_RESET = 350;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  // microcode addresses, in program order
  typedef enum logic [4:0] {
    S_START_AA, S_START_BB, S_START_AB, S_START_ACC, S_START_SUB, S_START_END,
    S_TEST_L, S_TEST_R, S_TEST_CMP,
    S_ENT_TX, S_ENT_BT, S_ENT_TY, S_ENT_AT, S_ENT_AB, S_ENT_END,
    S_EMIT2, S_R2_AY, S_R2_SUB, S_R2_BX, S_R2_ADD, S_R2_END,
    S_FIN,
    S_EMIT1, S_R1_BX, S_R1_ADD, S_R1_SUB, S_R1_END
  } step_t;

  // multiplier operand sources
  typedef enum logic [3:0] {
    SRC_A, SRC_B, SRC_A2, SRC_B2, SRC_TX, SRC_TY, SRC_2YM1, SRC_X1, SRC_PROD
  } src_t;

  typedef enum logic [1:0] {BASE_ZERO, BASE_ACC, BASE_P} base_t;
  typedef enum logic [1:0] {TERM_PROD, TERM_A2, TERM_B2} term_t;

  typedef enum logic [2:0] {
    COND_NONE, COND_P_NEG, COND_P_POS, COND_R1_HOLD, COND_Y_ZERO
  } cond_t;

  typedef struct packed {
    logic        mul_en;
    src_t        mul_l;
    src_t        mul_r;
    logic        ld_acc;
    logic        ld_p;
    base_t       alu_base;
    term_t       alu_term;
    logic        alu_sub;
    logic [1:0]  alu_shift;
    logic        ld_a2;
    logic        ld_b2;
    logic        init_walk;
    logic        set_region;
    logic        end_walk;
    logic        x_inc;
    logic        y_dec;
    logic        emit;
    cond_t       jmp_cond;
    step_t       jmp_target;
    logic        done;
  } uop_t;

  typedef struct packed {
    logic p_neg;
    logic p_pos;
    logic r1_hold;
    logic y_zero;
    logic walking;
    logic region_two;
  } dp_flags_t;

  // control store; p is kept as four times the real decision value
  function automatic uop_t mpe_ucode(step_t s);
    uop_t u;
    u = '0;
    unique case (s)
      // start: a2 = a*a, b2 = b*b, p = 4b2 - 4a2*b + a2
      S_START_AA: begin
        u.mul_en = 1'b1; u.mul_l = SRC_A; u.mul_r = SRC_A;
      end
      S_START_BB: begin
        u.ld_a2 = 1'b1;
        u.mul_en = 1'b1; u.mul_l = SRC_B; u.mul_r = SRC_B;
      end
      S_START_AB: begin
        u.ld_b2 = 1'b1;
        u.mul_en = 1'b1; u.mul_l = SRC_A2; u.mul_r = SRC_B;
      end
      S_START_ACC: begin
        u.ld_acc = 1'b1; u.alu_base = BASE_ZERO; u.alu_term = TERM_B2; u.alu_shift = 2'd2;
      end
      S_START_SUB: begin
        u.ld_acc = 1'b1; u.alu_base = BASE_ACC; u.alu_term = TERM_PROD;
        u.alu_sub = 1'b1; u.alu_shift = 2'd2;
      end
      S_START_END: begin
        u.ld_p = 1'b1; u.alu_base = BASE_ACC; u.alu_term = TERM_A2;
        u.init_walk = 1'b1; u.done = 1'b1;
      end
      // region 1 test: a2*(2y-1) > 2*b2*(x+1)
      S_TEST_L: begin
        u.mul_en = 1'b1; u.mul_l = SRC_A2; u.mul_r = SRC_2YM1;
      end
      S_TEST_R: begin
        u.ld_acc = 1'b1; u.alu_base = BASE_ZERO; u.alu_term = TERM_PROD;
        u.mul_en = 1'b1; u.mul_l = SRC_B2; u.mul_r = SRC_X1;
      end
      S_TEST_CMP: begin
        u.jmp_cond = COND_R1_HOLD; u.jmp_target = S_EMIT1;
      end
      // switch to region 2: p = b2*tx^2 + 4a2*ty^2 - 4a2*b2
      S_ENT_TX: begin
        u.set_region = 1'b1;
        u.mul_en = 1'b1; u.mul_l = SRC_TX; u.mul_r = SRC_TX;
      end
      S_ENT_BT: begin
        u.mul_en = 1'b1; u.mul_l = SRC_B2; u.mul_r = SRC_PROD;
      end
      S_ENT_TY: begin
        u.ld_acc = 1'b1; u.alu_base = BASE_ZERO; u.alu_term = TERM_PROD;
        u.mul_en = 1'b1; u.mul_l = SRC_TY; u.mul_r = SRC_TY;
      end
      S_ENT_AT: begin
        u.mul_en = 1'b1; u.mul_l = SRC_A2; u.mul_r = SRC_PROD;
      end
      S_ENT_AB: begin
        u.ld_acc = 1'b1; u.alu_base = BASE_ACC; u.alu_term = TERM_PROD; u.alu_shift = 2'd2;
        u.mul_en = 1'b1; u.mul_l = SRC_A2; u.mul_r = SRC_B2;
      end
      S_ENT_END: begin
        u.ld_p = 1'b1; u.alu_base = BASE_ACC; u.alu_term = TERM_PROD;
        u.alu_sub = 1'b1; u.alu_shift = 2'd2;
      end
      // region 2 point and update
      S_EMIT2: begin
        u.emit = 1'b1; u.jmp_cond = COND_Y_ZERO; u.jmp_target = S_FIN;
      end
      S_R2_AY: begin
        u.mul_en = 1'b1; u.mul_l = SRC_A2; u.mul_r = SRC_TY;
      end
      S_R2_SUB: begin
        u.ld_acc = 1'b1; u.alu_base = BASE_P; u.alu_term = TERM_PROD;
        u.alu_sub = 1'b1; u.alu_shift = 2'd3;
        u.jmp_cond = COND_P_POS; u.jmp_target = S_R2_END;
      end
      S_R2_BX: begin
        u.mul_en = 1'b1; u.mul_l = SRC_B2; u.mul_r = SRC_X1;
      end
      S_R2_ADD: begin
        u.ld_acc = 1'b1; u.alu_base = BASE_ACC; u.alu_term = TERM_PROD; u.alu_shift = 2'd3;
        u.x_inc = 1'b1;
      end
      S_R2_END: begin
        u.ld_p = 1'b1; u.alu_base = BASE_ACC; u.alu_term = TERM_A2; u.alu_shift = 2'd2;
        u.y_dec = 1'b1; u.done = 1'b1;
      end
      S_FIN: begin
        u.end_walk = 1'b1; u.done = 1'b1;
      end
      // region 1 point and update
      S_EMIT1: begin
        u.emit = 1'b1;
      end
      S_R1_BX: begin
        u.mul_en = 1'b1; u.mul_l = SRC_B2; u.mul_r = SRC_X1;
      end
      S_R1_ADD: begin
        u.ld_acc = 1'b1; u.alu_base = BASE_P; u.alu_term = TERM_PROD; u.alu_shift = 2'd3;
        u.mul_en = 1'b1; u.mul_l = SRC_A2; u.mul_r = SRC_TY;
        u.jmp_cond = COND_P_NEG; u.jmp_target = S_R1_END;
      end
      S_R1_SUB: begin
        u.ld_acc = 1'b1; u.alu_base = BASE_ACC; u.alu_term = TERM_PROD;
        u.alu_sub = 1'b1; u.alu_shift = 2'd3;
        u.y_dec = 1'b1;
      end
      S_R1_END: begin
        u.ld_p = 1'b1; u.alu_base = BASE_ACC; u.alu_term = TERM_B2; u.alu_shift = 2'd2;
        u.x_inc = 1'b1; u.done = 1'b1;
      end
      default: begin
        u.done = 1'b1;
      end
    endcase
    return u;
  endfunction

endpackage
`default_nettype wire

>>> hdl/mpe_sequencer.sv
// microcode sequencer: step counter, control store lookup, conditional jumps, dispatch
`timescale 1ns / 1ps
`default_nettype none
module mpe_sequencer (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic             cmd,
  input  logic             hold,
  input  mpe_pkg::dp_flags_t flags,
  output logic             busy,
  output logic             fire,
  output mpe_pkg::uop_t    uop
);
  import mpe_pkg::*;

  step_t step;
  step_t step_next;
  logic  busy_next;
  logic  take;

  assign uop  = mpe_ucode(step);
  assign fire = busy && !hold;

  always_comb begin
    unique case (uop.jmp_cond)
      COND_NONE:    take = 1'b0;
      COND_P_NEG:   take = flags.p_neg;
      COND_P_POS:   take = flags.p_pos;
      COND_R1_HOLD: take = flags.r1_hold;
      COND_Y_ZERO:  take = flags.y_zero;
      default:      take = 1'b0;
    endcase
  end

  always_comb begin
    busy_next = busy;
    step_next = step;
    if (!busy) begin
      if (accept) begin
        if (cmd == CMD_START) begin
          busy_next = 1'b1;
          step_next = S_START_AA;
        end else if (flags.walking) begin
          busy_next = 1'b1;
          step_next = flags.region_two ? S_EMIT2 : S_TEST_L;
        end
      end
    end else if (fire) begin
      if (uop.done) begin
        busy_next = 1'b0;
      end else if (take) begin
        step_next = uop.jmp_target;
      end else begin
        step_next = step_t'(step + 5'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= S_START_AA;
    end else begin
      busy <= busy_next;
      step <= step_next;
    end
  end

endmodule
`default_nettype wire

>>> hdl/mpe_datapath.sv
// datapath: shared multiplier, accumulator adder, walk registers and decision value
`timescale 1ns / 1ps
`default_nettype none
module mpe_datapath #(
  parameter int AXIS_BITS = mpe_pkg::AXIS_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  logic [AXIS_BITS-1:0] semi_axis_x,
  input  logic [AXIS_BITS-1:0] semi_axis_y,
  input  logic                 fire,
  input  mpe_pkg::uop_t        uop,
  output mpe_pkg::dp_flags_t   flags,
  output logic [AXIS_BITS:0]   offset_x,
  output logic [AXIS_BITS:0]   offset_y
);
  import mpe_pkg::*;

  localparam int OFF_W = AXIS_BITS + 1;
  localparam int SQ_W  = 2 * AXIS_BITS;
  localparam int MW    = 2 * AXIS_BITS + 4;
  localparam int DW    = 4 * AXIS_BITS + 6;

  logic [AXIS_BITS-1:0]   axis_x;
  logic [AXIS_BITS-1:0]   axis_y;
  logic [SQ_W-1:0]        axis_x_squared;
  logic [SQ_W-1:0]        axis_y_squared;
  logic signed [DW-1:0]   decision;
  logic signed [DW-1:0]   acc;
  logic signed [DW-1:0]   prod;
  logic                   region_two;
  logic                   walking;

  logic signed [MW-1:0]   v_a, v_b, v_a2, v_b2, v_x, v_y;
  logic signed [MW-1:0]   v_tx, v_ty, v_2ym1, v_x1, v_prod;
  logic signed [MW-1:0]   mul_l_val, mul_r_val;
  logic signed [2*MW-1:0] prod_full;
  logic signed [DW-1:0]   base_val, term_raw, term_sh, alu_sum;

  assign v_a    = $signed(MW'(axis_x));
  assign v_b    = $signed(MW'(axis_y));
  assign v_a2   = $signed(MW'(axis_x_squared));
  assign v_b2   = $signed(MW'(axis_y_squared));
  assign v_x    = $signed(MW'(offset_x));
  assign v_y    = $signed(MW'(offset_y));
  assign v_tx   = v_x + v_x + $signed(MW'(1));
  assign v_ty   = v_y - $signed(MW'(1));
  assign v_2ym1 = v_y + v_y - $signed(MW'(1));
  assign v_x1   = v_x + $signed(MW'(1));
  assign v_prod = prod[MW-1:0];

  always_comb begin
    case (uop.mul_l)
      SRC_A:    mul_l_val = v_a;
      SRC_B:    mul_l_val = v_b;
      SRC_A2:   mul_l_val = v_a2;
      SRC_B2:   mul_l_val = v_b2;
      SRC_TX:   mul_l_val = v_tx;
      SRC_TY:   mul_l_val = v_ty;
      SRC_2YM1: mul_l_val = v_2ym1;
      SRC_X1:   mul_l_val = v_x1;
      SRC_PROD: mul_l_val = v_prod;
      default:  mul_l_val = '0;
    endcase
  end

  always_comb begin
    case (uop.mul_r)
      SRC_A:    mul_r_val = v_a;
      SRC_B:    mul_r_val = v_b;
      SRC_A2:   mul_r_val = v_a2;
      SRC_B2:   mul_r_val = v_b2;
      SRC_TX:   mul_r_val = v_tx;
      SRC_TY:   mul_r_val = v_ty;
      SRC_2YM1: mul_r_val = v_2ym1;
      SRC_X1:   mul_r_val = v_x1;
      SRC_PROD: mul_r_val = v_prod;
      default:  mul_r_val = '0;
    endcase
  end

  assign prod_full = mul_l_val * mul_r_val;

  always_comb begin
    case (uop.alu_base)
      BASE_ZERO: base_val = '0;
      BASE_ACC:  base_val = acc;
      BASE_P:    base_val = decision;
      default:   base_val = '0;
    endcase
  end

  always_comb begin
    case (uop.alu_term)
      TERM_PROD: term_raw = prod;
      TERM_A2:   term_raw = $signed(DW'(axis_x_squared));
      TERM_B2:   term_raw = $signed(DW'(axis_y_squared));
      default:   term_raw = '0;
    endcase
  end

  assign term_sh = term_raw <<< uop.alu_shift;
  assign alu_sum = uop.alu_sub ? (base_val - term_sh) : (base_val + term_sh);

  assign flags.p_neg      = decision[DW-1];
  assign flags.p_pos      = !decision[DW-1] && (decision != '0);
  // region 1 holds while a2*(2y-1) > 2*b2*(x+1)
  assign flags.r1_hold    = acc > (prod <<< 1);
  assign flags.y_zero     = (offset_y == '0);
  assign flags.walking    = walking;
  assign flags.region_two = region_two;

  always_ff @(posedge clk) begin
    if (load) begin
      axis_x <= semi_axis_x;
      axis_y <= semi_axis_y;
    end
    if (fire) begin
      if (uop.mul_en) prod <= prod_full[DW-1:0];
      if (uop.ld_acc) acc <= alu_sum;
      if (uop.ld_p) decision <= alu_sum;
      if (uop.ld_a2) axis_x_squared <= prod[SQ_W-1:0];
      if (uop.ld_b2) axis_y_squared <= prod[SQ_W-1:0];
      if (uop.init_walk) begin
        offset_x <= '0;
        offset_y <= OFF_W'(axis_y);
      end else begin
        if (uop.x_inc) offset_x <= offset_x + OFF_W'(1);
        if (uop.y_dec) offset_y <= offset_y - OFF_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walking    <= 1'b0;
      region_two <= 1'b0;
    end else if (fire) begin
      if (uop.init_walk) begin
        walking    <= 1'b1;
        region_two <= 1'b0;
      end else begin
        if (uop.set_region) region_two <= 1'b1;
        if (uop.end_walk) walking <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/midpoint_ellipse_rasterizer_top.sv
// top level of the midpoint ellipse rasterizer: handshakes, center registers, output word
//
// channel   direction  fields (lowest bit first)
// s_axis    in         tdata: semi_axis_x, semi_axis_y; tuser: cmd
// m_axis    out        tdata: right_x, left_x, upper_y, lower_y; tuser: in_region_two;
//                      tlast: last_point
// cfg       in         cfg_index: register (0 center_x, 1 center_y); cfg_data: value
//
// one word is taken while the sequencer is idle; its microprogram then runs one step a cycle
// except while an emit step holds; there are step sequences for the start, a region 1 point,
// a region 2 point, the point that switches regions and the final point; a step word taken
// while no walk is active does nothing
// all of these steps share the single multiplier and accumulator adder
// reset is synchronous; a result waits in the output register, and an emit step holds there
// only if that register is still full and not being taken when the next point is ready
`timescale 1ns / 1ps
`default_nettype none
module midpoint_ellipse_rasterizer_top #(
  parameter int  AXIS_BITS  = mpe_pkg::AXIS_BITS_DEF,
  parameter int  COORD_BITS = mpe_pkg::COORD_BITS_DEF,
  localparam int IN_DATA_W  = ((2 * AXIS_BITS + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [IN_DATA_W-1:0]              s_axis_tdata,   // semi_axis_x, semi_axis_y
  input  logic                              s_axis_tuser,   // cmd
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [mpe_pkg::OUT_DATA_W-1:0]    m_axis_tdata,   // right_x, left_x, upper_y, lower_y
  output logic                              m_axis_tuser,   // in_region_two
  output logic                              m_axis_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mpe_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [COORD_BITS-1:0]             cfg_data
);
  import mpe_pkg::*;

  logic [COORD_BITS-1:0] center_x;
  logic [COORD_BITS-1:0] center_y;
  logic                  s_accept;
  logic                  busy;
  logic                  fire;
  logic                  hold;
  logic                  emit_fire;
  uop_t                  uop;
  dp_flags_t             flags;
  logic [AXIS_BITS:0]    offset_x;
  logic [AXIS_BITS:0]    offset_y;
  logic [OUT_BITS-1:0]   right_x, left_x, upper_y, lower_y;

  assign s_axis_tready = !busy;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  // an emit step waits while the previous word is still unclaimed
  assign hold      = busy && uop.emit && m_axis_tvalid && !m_axis_tready;
  assign emit_fire = fire && uop.emit;

  mpe_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .accept (s_accept),
    .cmd    (s_axis_tuser),
    .hold   (hold),
    .flags  (flags),
    .busy   (busy),
    .fire   (fire),
    .uop    (uop)
  );

  mpe_datapath #(
    .AXIS_BITS (AXIS_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .load        (s_accept && (s_axis_tuser == CMD_START)),
    .semi_axis_x (s_axis_tdata[AXIS_BITS-1:0]),
    .semi_axis_y (s_axis_tdata[2*AXIS_BITS-1:AXIS_BITS]),
    .fire        (fire),
    .uop         (uop),
    .flags       (flags),
    .offset_x    (offset_x),
    .offset_y    (offset_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= COORD_BITS'(CENTER_X_RESET);
      center_y <= COORD_BITS'(CENTER_Y_RESET);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CENTER_X: center_x <= cfg_data;
        REG_CENTER_Y: center_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // coordinates wrap to the output width
  assign right_x = OUT_BITS'(center_x) + OUT_BITS'(offset_x);
  assign left_x  = OUT_BITS'(center_x) - OUT_BITS'(offset_x);
  assign upper_y = OUT_BITS'(center_y) + OUT_BITS'(offset_y);
  assign lower_y = OUT_BITS'(center_y) - OUT_BITS'(offset_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit_fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      m_axis_tdata <= {{(OUT_DATA_W - 4 * OUT_BITS){1'b0}}, lower_y, upper_y, left_x, right_x};
      m_axis_tuser <= flags.region_two;
      m_axis_tlast <= flags.region_two && flags.y_zero;
    end
  end

endmodule
`default_nettype wire

>>> hdl/mpe_checker.sv
// port-level checks for the midpoint ellipse rasterizer, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module mpe_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [mpe_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                           m_axis_tuser,
  input logic                           m_axis_tlast
);
  import mpe_pkg::*;

  logic s_word;
  logic [OUT_BITS-1:0] upper_y, lower_y;

  assign s_word  = s_axis_tvalid && s_axis_tready;
  assign upper_y = m_axis_tdata[3*OUT_BITS-1:2*OUT_BITS];
  assign lower_y = m_axis_tdata[4*OUT_BITS-1:3*OUT_BITS];

  // a start word makes the sequencer busy, so input ready drops once it is taken
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    s_word && (s_axis_tuser == CMD_START) |=> !s_axis_tready)
    else $error("input ready right after a start word");

  // the final point lies on the horizontal axis
  a_last_on_axis: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> upper_y == lower_y)
    else $error("last point has nonzero y offset");

  // the final point is always a region 2 point
  a_last_region: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
    else $error("last point outside region 2");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result word changed while stalled");

endmodule

bind midpoint_ellipse_rasterizer_top mpe_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
